// File: hdl/stt_pkg.sv
// stt_pkg: types, constants and character classes for the source text tokenizer.
// No dependencies; used by all files in hdl.
package stt_pkg;

    localparam int TEXT_ADDR_BITS_DEF = 20;
    localparam int CNT_W = 20;
    localparam int LEN_W = 21;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // token kinds and internal modes share one 5-bit code space
    localparam logic [4:0] K_OP     = 5'd0;
    localparam logic [4:0] K_IDENT  = 5'd1;
    localparam logic [4:0] K_INT    = 5'd2;
    localparam logic [4:0] K_UINT   = 5'd3;
    localparam logic [4:0] K_LONG   = 5'd4;
    localparam logic [4:0] K_ULONG  = 5'd5;
    localparam logic [4:0] K_DOUBLE = 5'd6;
    localparam logic [4:0] K_FLOAT  = 5'd7;
    localparam logic [4:0] K_STR    = 5'd8;
    localparam logic [4:0] K_EXP    = 5'd9;
    localparam logic [4:0] K_EXPS   = 5'd10;
    localparam logic [4:0] M_SPACE  = 5'd11;
    localparam logic [4:0] M_POTC   = 5'd12;
    localparam logic [4:0] M_POTD   = 5'd13;
    localparam logic [4:0] M_DEXT   = 5'd14;
    localparam logic [4:0] M_LINEC  = 5'd15;
    localparam logic [4:0] M_BLOCK  = 5'd16;
    localparam logic [4:0] M_BSTAR  = 5'd17;
    localparam logic [4:0] M_HALT   = 5'd18;

    localparam logic [3:0] E_BLOCK  = 4'd0;
    localparam logic [3:0] E_STRING = 4'd1;
    localparam logic [3:0] E_SUFFIX = 4'd2;

    localparam logic [7:0] CH_DOT  = 8'h2E;
    localparam logic [7:0] CH_U    = 8'h75;
    localparam logic [7:0] CH_L    = 8'h6C;
    localparam logic [7:0] CH_E    = 8'h65;
    localparam logic [7:0] CH_F    = 8'h66;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_BSL  = 8'h5C;
    localparam logic [7:0] CH_SL   = 8'h2F;
    localparam logic [7:0] CH_STAR = 8'h2A;
    localparam logic [7:0] CH_PLUS = 8'h2B;
    localparam logic [7:0] CH_MIN  = 8'h2D;
    localparam logic [7:0] CH_SP   = 8'h20;
    localparam logic [7:0] CH_TAB  = 8'h09;
    localparam logic [7:0] CH_QUOT = 8'h22;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_of_text;
    } in_word_t;

    typedef struct packed {
        logic             is_error;
        logic [3:0]       kind_code;
        logic [CNT_W-1:0] start_offset;
        logic [LEN_W-1:0] text_length;
        logic [CNT_W-1:0] line_number;
        logic [CNT_W-1:0] column_number;
        logic             last_result;
    } out_word_t;

    // class flags computed in the front end
    typedef struct packed {
        logic digit;
        logic op;
        logic nl;     // CR or LF
        logic blank;  // space or tab
    } char_class_t;

    typedef struct packed {
        logic [7:0]  ch;
        logic        last;
        char_class_t cls;
    } cmd_t;

    function automatic logic is_op_char(input logic [7:0] c);
        logic r;
        case (c)
            8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h26, 8'h7C, 8'h5E, 8'h28, 8'h29,
            8'h5B, 8'h5D, 8'h3D, 8'h7B, 8'h7D, 8'h7E, 8'h21, 8'h3C, 8'h3E,
            8'h2C, 8'h3B, 8'h3F, 8'h3A: r = 1'b1;
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] inc_cnt(input logic [CNT_W-1:0] x);
        return (x != CNT_MAX) ? x + 1'b1 : CNT_MAX;
    endfunction

endpackage

// File: hdl/stt_front.sv
// stt_front: accepts source bytes and classifies them.
// Depends on stt_pkg.
module stt_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  stt_pkg::in_word_t in_word,
    output logic            cmd_valid,
    input  logic            cmd_stall,
    output stt_pkg::cmd_t   cmd
);
    import stt_pkg::*;

    logic  valid_reg;
    cmd_t  cmd_reg;
    cmd_t  cmd_next;

    assign in_stall  = valid_reg && cmd_stall;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

    always_comb
    begin
        cmd_next.ch        = in_word.char_code;
        cmd_next.last      = in_word.last_of_text;
        cmd_next.cls.digit = (in_word.char_code >= 8'h30) && (in_word.char_code <= 8'h39);
        cmd_next.cls.op    = is_op_char(in_word.char_code);
        cmd_next.cls.nl    = (in_word.char_code == CH_CR) || (in_word.char_code == CH_LF);
        cmd_next.cls.blank = (in_word.char_code == CH_SP) || (in_word.char_code == CH_TAB);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!in_stall)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
            cmd_reg <= cmd_next;
    end
endmodule

// File: hdl/stt_queue.sv
// stt_queue: result word FIFO between lexer core and output port.
// Depends on stt_pkg.
module stt_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [1:0]          push_cnt,
    input  stt_pkg::out_word_t  push0,
    input  stt_pkg::out_word_t  push1,
    input  stt_pkg::out_word_t  push2,
    output logic                room3,
    output logic                out_valid,
    input  logic                out_stall,
    output stt_pkg::out_word_t  out_word
);
    import stt_pkg::*;

    localparam int DEPTH = 8;
    localparam int AW = 3;

    out_word_t     mem [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg, cnt_next;
    logic          pop;

    assign out_valid = (cnt_reg != '0);
    assign out_word  = mem[rp_reg];
    assign pop       = out_valid && !out_stall;
    // three free slots before this cycle's push, so any push fits
    assign room3     = cnt_reg <= (AW+1)'(DEPTH - 3);
    assign cnt_next  = cnt_reg + {2'b0, push_cnt} - {{AW{1'b0}}, pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_reg + AW'(push_cnt);
            rp_reg  <= rp_reg + AW'(pop);
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt >= 2'd1) mem[wp_reg]            <= push0;
        if (push_cnt >= 2'd2) mem[wp_reg + AW'(1)]   <= push1;
        if (push_cnt == 2'd3) mem[wp_reg + AW'(2)]   <= push2;
    end
endmodule

// File: hdl/stt_back.sv
// stt_back: lexer state machine; consumes classified bytes, produces results.
// Depends on stt_pkg.
module stt_back #(
    parameter int TEXT_ADDR_BITS = stt_pkg::TEXT_ADDR_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  stt_pkg::cmd_t      cmd,
    input  logic               room3,
    output logic [1:0]         push_cnt,
    output stt_pkg::out_word_t push0,
    output stt_pkg::out_word_t push1,
    output stt_pkg::out_word_t push2
);
    import stt_pkg::*;

    localparam int PW = TEXT_ADDR_BITS + 1;
    localparam logic [PW-1:0] POS_CAP = PW'(1) << TEXT_ADDR_BITS;

    logic [4:0]       mode_reg, mode_next;
    logic [PW-1:0]    tstart_reg, tstart_next;
    logic [PW-1:0]    pos_reg, pos_next;
    logic [CNT_W-1:0] line_reg, line_next;
    logic [CNT_W-1:0] cst_reg, cst_next;
    logic [CNT_W-1:0] cend_reg, cend_next;
    logic             cr_reg, cr_next;

    out_word_t res [3];
    logic [1:0] n;
    logic       go;

    assign cmd_stall = !room3;
    assign go        = cmd_valid && room3;

    function automatic logic [PW-1:0] npos(input logic [PW-1:0] p);
        return (p < POS_CAP) ? p + 1'b1 : POS_CAP;
    endfunction

    always_comb
    begin
        logic [7:0]    c;
        logic [7:0]    lc;
        logic [4:0]    m;
        logic [PW-1:0] p;
        logic [PW-1:0] e;
        logic [PW-1:0] ln;
        logic          brk;
        c  = cmd.ch;
        lc = cmd.ch | 8'h20;
        p  = pos_reg;
        mode_next   = mode_reg;
        tstart_next = tstart_reg;
        pos_next    = pos_reg;
        line_next   = line_reg;
        cst_next    = cst_reg;
        cend_next   = cend_reg;
        cr_next     = cr_reg;
        n = 2'd0;
        m = 5'd0;
        e = '0;
        ln = '0;
        brk = 1'b0;
        for (int i = 0; i < 3; i++)
            res[i] = '0;

        if (mode_reg != M_HALT)
        begin
            if (mode_reg == M_LINEC && cmd.cls.nl)
                mode_next = M_SPACE;
            if (mode_next == M_LINEC)
            begin
                if (cr_next && c != CH_LF) cr_next = 1'b0;
            end
            else if (mode_next == M_BSTAR && c == CH_SL)
            begin
                cst_next  = (cend_next != '0) ? cend_next - 1'b1 : '0;
                mode_next = M_SPACE;
            end
            else if (mode_next == M_BSTAR || mode_next == M_BLOCK)
            begin
                if (mode_next == M_BSTAR) cr_next = 1'b0;
                if (c == CH_STAR)
                    mode_next = M_BSTAR;
                else
                begin
                    if (cr_next && c != CH_LF) cr_next = 1'b0;
                    if (cmd.cls.nl)
                    begin
                        brk = (c != CH_LF) || !cr_next;
                        if (brk && c == CH_CR) cr_next = 1'b1;
                        if (brk)
                        begin
                            line_next = inc_cnt(line_next);
                            cst_next  = '0;
                            cend_next = '0;
                        end
                    end
                    mode_next = M_BLOCK;
                end
            end
            else
            begin
                // normal byte; close_tok / emit_op expanded inline
                if (cr_next && c != CH_LF) cr_next = 1'b0;
                if ((mode_next == M_POTC && c != CH_SL && c != CH_STAR) ||
                    (mode_next == M_POTD && !cmd.cls.digit))
                begin
                    res[n] = '{1'b0, K_OP[3:0], CNT_W'(tstart_next),
                               LEN_W'((p >= tstart_next) ? p - tstart_next : '0),
                               line_next, cst_next, 1'b0};
                    n = n + 2'd1;
                    mode_next = M_SPACE; tstart_next = p; cst_next = cend_next;
                end
                m = mode_next;

                if (cmd.cls.digit && m != K_UINT && m != K_LONG && m != K_ULONG)
                begin
                    if (m == M_SPACE)
                    begin
                        mode_next = K_INT; tstart_next = p;
                    end
                    else if (m == M_POTD) mode_next = K_DOUBLE;
                    else if (m == K_EXP || m == K_EXPS) mode_next = M_DEXT;
                end
                else if ((c == CH_PLUS || c == CH_MIN) && m == K_EXP)
                    mode_next = K_EXPS;
                else if (c == CH_DOT && (m == M_SPACE || m == K_INT || m == K_STR))
                begin
                    if (m == M_SPACE)
                    begin
                        mode_next = M_POTD; tstart_next = p;
                    end
                    else if (m == K_INT) mode_next = K_DOUBLE;
                end
                else if (lc == CH_U && m == K_INT)
                    mode_next = K_UINT;
                else if (lc == CH_L && (m == K_INT || m == K_UINT))
                    mode_next = (m == K_UINT) ? K_ULONG : K_LONG;
                else if (lc == CH_E && (m == K_INT || m == K_DOUBLE))
                    mode_next = K_EXP;
                else if (lc == CH_F && (m == K_DOUBLE || m == M_DEXT))
                begin
                    e = npos(p);
                    res[n] = '{1'b0, K_FLOAT[3:0], CNT_W'(tstart_next),
                               LEN_W'((e >= tstart_next) ? e - tstart_next : '0),
                               line_next, cst_next, 1'b0};
                    n = n + 2'd1;
                    mode_next = M_SPACE; tstart_next = e; cst_next = cend_next;
                end
                else if (cmd.cls.op && m == M_POTC)
                begin
                    if (c == CH_SL) mode_next = M_LINEC;
                    else
                    begin
                        mode_next = M_BLOCK; cr_next = 1'b0;
                    end
                end
                else if (cmd.cls.op && m != K_STR && c == CH_SL)
                begin
                    if (m <= K_EXPS || m == M_DEXT)
                    begin
                        res[n] = '{1'b0, (m == M_DEXT) ? K_DOUBLE[3:0] : m[3:0],
                                   CNT_W'(tstart_next),
                                   LEN_W'((p >= tstart_next) ? p - tstart_next : '0),
                                   line_next, cst_next, 1'b0};
                        n = n + 2'd1;
                    end
                    cst_next = cend_next;
                    mode_next = M_POTC; tstart_next = p;
                end
                else if ((cmd.cls.op && m != K_STR) || (c == CH_DOT && m != K_STR) ||
                         (c == CH_BSL && m != K_STR && !cmd.cls.blank))
                begin
                    // emit_op: close pending, then one-byte op
                    if (m <= K_EXPS || m == M_DEXT)
                    begin
                        res[n] = '{1'b0, (m == M_DEXT) ? K_DOUBLE[3:0] : m[3:0],
                                   CNT_W'(tstart_next),
                                   LEN_W'((p >= tstart_next) ? p - tstart_next : '0),
                                   line_next, cst_next, 1'b0};
                        n = n + 2'd1;
                    end
                    cst_next = cend_next;
                    res[n] = '{1'b0, K_OP[3:0], CNT_W'(p), LEN_W'(npos(p) - p),
                               line_next, cst_next, 1'b0};
                    n = n + 2'd1;
                    mode_next = M_SPACE; tstart_next = npos(p);
                end
                else if (cmd.cls.blank && m != K_STR)
                begin
                    if (m <= K_EXPS || m == M_DEXT)
                    begin
                        res[n] = '{1'b0, (m == M_DEXT) ? K_DOUBLE[3:0] : m[3:0],
                                   CNT_W'(tstart_next),
                                   LEN_W'((p >= tstart_next) ? p - tstart_next : '0),
                                   line_next, cst_next, 1'b0};
                        n = n + 2'd1;
                    end
                    mode_next = M_SPACE; tstart_next = p; cst_next = cend_next;
                end
                else if (cmd.cls.nl)
                begin
                    if (m == K_STR)
                    begin
                        res[n] = '{1'b1, E_STRING, CNT_W'(tstart_next), '0,
                                   line_next, cst_next, 1'b0};
                        n = n + 2'd1;
                    end
                    brk = (c != CH_LF) || !cr_next;
                    if (brk && c == CH_CR) cr_next = 1'b1;
                    if (brk)
                    begin
                        if (m <= K_EXPS || m == M_DEXT)
                        begin
                            res[n] = '{1'b0, (m == M_DEXT) ? K_DOUBLE[3:0] : m[3:0],
                                       CNT_W'(tstart_next),
                                       LEN_W'((p >= tstart_next) ? p - tstart_next : '0),
                                       line_next, cst_next, 1'b0};
                            n = n + 2'd1;
                        end
                        mode_next = M_SPACE; tstart_next = p;
                        line_next = inc_cnt(line_next);
                        cst_next = '0; cend_next = '0;
                    end
                end
                else if (c == CH_QUOT)
                begin
                    if (m <= K_EXPS || m == M_DEXT)
                    begin
                        res[n] = '{1'b0, (m == M_DEXT) ? K_DOUBLE[3:0] : m[3:0],
                                   CNT_W'(tstart_next),
                                   LEN_W'((p >= tstart_next) ? p - tstart_next : '0),
                                   line_next, cst_next, 1'b0};
                        n = n + 2'd1;
                    end
                    cst_next = cend_next;
                    mode_next = M_SPACE; tstart_next = p;
                    if (m != K_STR)
                    begin
                        mode_next = K_STR; tstart_next = npos(p);
                    end
                end
                else if (c == CH_BSL && m != K_STR)
                begin
                    // unreachable: covered by the op branch above
                    mode_next = mode_next;
                end
                else if (m == M_SPACE)
                begin
                    cst_next = cend_next;
                    mode_next = K_IDENT; tstart_next = p;
                end
                else if (m == K_INT || m == K_UINT || m == K_LONG || m == K_ULONG ||
                         m == K_EXP || m == M_DEXT)
                begin
                    res[n] = '{1'b1, E_SUFFIX, CNT_W'(tstart_next), '0,
                               line_next, cst_next, 1'b0};
                    n = n + 2'd1;
                    mode_next = M_HALT;
                end
            end
            cend_next = inc_cnt(cend_next);
            pos_next  = npos(p);
        end

        if (cmd.last)
        begin
            if (mode_next == M_BLOCK || mode_next == M_BSTAR)
            begin
                res[n] = '{1'b1, E_BLOCK, CNT_W'(tstart_next), '0,
                           line_next, cst_next, 1'b0};
                n = n + 2'd1;
            end
            else if (mode_next != M_HALT && mode_next != M_LINEC)
            begin
                if (mode_next == K_STR)
                begin
                    res[n] = '{1'b1, E_STRING, CNT_W'(tstart_next), '0,
                               line_next, cst_next, 1'b0};
                    n = n + 2'd1;
                end
                if (mode_next <= K_EXPS || mode_next == M_POTC || mode_next == M_POTD ||
                    mode_next == M_DEXT)
                begin
                    ln = (pos_next >= tstart_next) ? pos_next - tstart_next : '0;
                    res[n] = '{1'b0,
                               (mode_next == M_DEXT) ? K_DOUBLE[3:0] :
                               (mode_next == M_POTC || mode_next == M_POTD) ? K_OP[3:0] :
                               mode_next[3:0],
                               CNT_W'(tstart_next), LEN_W'(ln),
                               line_next, cst_next, 1'b0};
                    n = n + 2'd1;
                end
            end
            mode_next = M_SPACE; tstart_next = '0; pos_next = '0;
            line_next = '0; cst_next = '0; cend_next = '0; cr_next = 1'b0;
        end

        if (n != 2'd0)
            res[n - 2'd1].last_result = 1'b1;
    end

    assign push_cnt = go ? n : 2'd0;
    assign push0 = res[0];
    assign push1 = res[1];
    assign push2 = res[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= M_SPACE;
            tstart_reg <= '0;
            pos_reg    <= '0;
            line_reg   <= '0;
            cst_reg    <= '0;
            cend_reg   <= '0;
            cr_reg     <= 1'b0;
        end
        else if (go)
        begin
            mode_reg   <= mode_next;
            tstart_reg <= tstart_next;
            pos_reg    <= pos_next;
            line_reg   <= line_next;
            cst_reg    <= cst_next;
            cend_reg   <= cend_next;
            cr_reg     <= cr_next;
        end
    end
endmodule

// File: hdl/source_text_tokenizer_core.sv
// Source text tokenizer: takes one source byte per cycle and returns token and
// error words. A front register classifies each byte, the lexer core updates
// its mode and counters and pushes up to three words per byte into an
// eight-word result queue; so one byte is taken every cycle while at most five
// words wait in the queue, and input stalls once more are waiting because the
// output side holds them. A byte is held in the front register, its words in the queue.
// Depends on stt_pkg, stt_front, stt_back, stt_queue.
module source_text_tokenizer_core #(
    parameter int TEXT_ADDR_BITS = stt_pkg::TEXT_ADDR_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  stt_pkg::in_word_t  in_word,
    output logic               out_valid,
    input  logic               out_stall,
    output stt_pkg::out_word_t out_word
);
    import stt_pkg::*;

    logic      cmd_valid, cmd_stall, room3;
    cmd_t      cmd;
    logic [1:0] push_cnt;
    out_word_t push0, push1, push2;

    stt_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .in_word(in_word), .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd)
    );

    stt_back #(.TEXT_ADDR_BITS(TEXT_ADDR_BITS)) u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd_stall(cmd_stall),
        .cmd(cmd), .room3(room3), .push_cnt(push_cnt),
        .push0(push0), .push1(push1), .push2(push2)
    );

    stt_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push_cnt(push_cnt), .push0(push0),
        .push1(push1), .push2(push2), .room3(room3), .out_valid(out_valid),
        .out_stall(out_stall), .out_word(out_word)
    );
endmodule

// File: hdl/stt_checker.sv
// stt_checker: port-level assertions for source_text_tokenizer_core.
// Depends on stt_pkg; bound to the top level below.
module stt_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input stt_pkg::out_word_t out_word
);
    import stt_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_word))
        else $error("stalled output word changed");

    // an empty queue always has room, so input never stalls then
    a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with empty queue");

    a_err_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.is_error |-> out_word.text_length == '0)
        else $error("error word with nonzero length");

    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.is_error |-> out_word.kind_code <= E_SUFFIX)
        else $error("bad error code");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_word.is_error |-> out_word.kind_code <= K_EXPS[3:0])
        else $error("bad token kind");
endmodule

bind source_text_tokenizer_core stt_checker u_stt_checker (
    .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
);
